>>> rtl/mfbr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfbr_pkg
// Shared types, constants and helpers of the MSB-first bit reader.
// ----------------------------------------------------------------------------
package mfbr_pkg;

    localparam int FUNC_W     = 3;
    localparam int COUNT_W    = 26;
    localparam int WORD_W     = 32;
    localparam int BITS_W     = 6;
    localparam int SHIFT_W    = 5;
    localparam int OUT_ADDR_W = 24;

    // Function codes carried on the func field.
    localparam logic [FUNC_W-1:0] FUNC_READ_N     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ_32    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_SKIP_N     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_SKIP_LONG  = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_START      = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_WORD  = 3'd5;

    localparam logic [BITS_W-1:0] WINDOW_FULL = 6'd32;
    localparam logic [WORD_W-1:0] BYTE1_MASK  = 32'h0000_FF00;

    // Decoded operation class, worked out by the front end.
    typedef enum logic [2:0] {
        OP_READ,
        OP_READ32,
        OP_SKIP,
        OP_SKIP_LONG,
        OP_START,
        OP_LOAD,
        OP_BAD
    } t_op;

    // One queued item: class, bits needed from the window, raw fields.
    typedef struct packed {
        t_op                op;
        logic [BITS_W-1:0]  need;
        logic [COUNT_W-1:0] count;
        logic [WORD_W-1:0]  word;
    } t_item;

    // The memory word carries its first stream byte in bits 7:0.
    function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] w);
        swap_bytes = ((w & 32'h0000_00FF) << 24) | ((w & BYTE1_MASK) << 8) |
                     ((w >> 8) & BYTE1_MASK) | (w >> 24);
    endfunction

endpackage
`default_nettype wire

>>> rtl/mfbr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfbr_front
// Accepts input transfers, decodes the function code and pushes the item.
// ----------------------------------------------------------------------------
module mfbr_front (
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [mfbr_pkg::FUNC_W-1:0]  i_func,
    input  wire logic [mfbr_pkg::COUNT_W-1:0] i_count,
    input  wire logic [mfbr_pkg::WORD_W-1:0]  i_word,
    input  wire logic                        i_queue_full,
    output logic                             o_push,
    output mfbr_pkg::t_item                  o_item
);
    import mfbr_pkg::*;

    t_op op;

    always_comb begin
        unique case (i_func)
            FUNC_READ_N:    op = OP_READ;
            FUNC_READ_32:   op = OP_READ32;
            FUNC_SKIP_N:    op = OP_SKIP;
            FUNC_SKIP_LONG: op = OP_SKIP_LONG;
            FUNC_START:     op = OP_START;
            FUNC_LOAD_WORD: op = OP_LOAD;
            default:        op = OP_BAD;
        endcase
    end

    assign o_in_stall = i_queue_full;
    assign o_push     = i_in_valid && !i_queue_full;

    // A full-word read needs all 32 bits; short reads and skips use count[4:0].
    assign o_item.op    = op;
    assign o_item.need  = (op == OP_READ32) ? WINDOW_FULL : {1'b0, i_count[SHIFT_W-1:0]};
    assign o_item.count = i_count;
    assign o_item.word  = i_word;

endmodule
`default_nettype wire

>>> rtl/mfbr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfbr_queue
// Two-entry item queue between the front end and the execution stage.
// ----------------------------------------------------------------------------
module mfbr_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire mfbr_pkg::t_item i_item,
    input  wire logic            i_pop,
    output mfbr_pkg::t_item      o_item,
    output logic                 o_empty,
    output logic                 o_full,
    output logic [1:0]           o_level
);
    import mfbr_pkg::*;

    localparam int Depth = 2;

    t_item      r_mem [Depth];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_level, n_level;

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_level  = r_level;
        if (i_push && !i_pop) begin
            n_level = r_level + 2'd1;
        end else if (i_pop && !i_push) begin
            n_level = r_level - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rd_ptr];
    assign o_empty = (r_level == 2'd0);
    assign o_full  = (r_level == 2'(Depth));
    assign o_level = r_level;

endmodule
`default_nettype wire

>>> rtl/mfbr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mfbr_back
// Execution stage: bit window, word pointer, load ordering and result register.
// ----------------------------------------------------------------------------
module mfbr_back #(
    parameter int WORD_ADDR_BITS = 24
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    input  wire mfbr_pkg::t_item                i_item,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [mfbr_pkg::WORD_W-1:0]         o_value,
    output logic [mfbr_pkg::OUT_ADDR_W-1:0]     o_word_address,
    output logic                                o_word_taken,
    output logic                                o_load_needed,
    output logic                                o_bad_order
);
    import mfbr_pkg::*;

    localparam int OffW = COUNT_W + 1;
    localparam int ExtW = (WORD_ADDR_BITS > OUT_ADDR_W) ? WORD_ADDR_BITS : OUT_ADDR_W;

    logic [WORD_W-1:0]         r_window, n_window;
    logic [BITS_W-1:0]         r_bits, n_bits;
    logic [WORD_ADDR_BITS-1:0] r_ptr, n_ptr;
    logic                      r_pending, n_pending;
    logic [SHIFT_W-1:0]        r_shift, n_shift;

    logic                      r_out_valid;
    logic [WORD_W-1:0]         r_value;
    logic                      r_taken;
    logic                      r_bad;

    logic [WORD_W-1:0]         swapped;
    logic [WORD_W-1:0]         head;
    logic [WORD_W-1:0]         got;
    logic [WORD_W-1:0]         fill_window;
    logic [BITS_W-1:0]         remain;
    logic                      short_window;
    logic [OffW-1:0]           offset;
    logic [WORD_W-1:0]         value;
    logic                      taken;
    logic                      bad;
    logic [ExtW-1:0]           ptr_ext;

    assign o_pop = i_valid && (!r_out_valid || !i_out_stall);

    // Shared datapath. A shift by 32 on a 32-bit value gives zero, which covers
    // the zero-length read and the empty-window refill without special arms.
    assign swapped      = swap_bytes(i_item.word);
    assign head         = r_window >> (WINDOW_FULL - i_item.need);
    assign short_window = (r_bits < i_item.need);
    assign remain       = r_bits + WINDOW_FULL - i_item.need;
    assign fill_window  = swapped << (WINDOW_FULL - remain);
    assign got          = swapped >> remain;
    assign offset       = OffW'(i_item.count) + OffW'(64) - OffW'(r_bits);

    always_comb begin
        n_window  = r_window;
        n_bits    = r_bits;
        n_ptr     = r_ptr;
        n_pending = r_pending;
        n_shift   = r_shift;
        value     = '0;
        taken     = 1'b0;
        bad       = (i_item.op == OP_BAD) ||
                    (r_pending && i_item.op != OP_LOAD) ||
                    (!r_pending && i_item.op == OP_LOAD);
        if (!bad) begin
            unique case (i_item.op)
                OP_READ, OP_READ32, OP_SKIP: begin
                    if (short_window) begin
                        n_window = fill_window;
                        n_bits   = remain;
                        n_ptr    = r_ptr + WORD_ADDR_BITS'(1);
                        taken    = 1'b1;
                        value    = head | got;
                    end else begin
                        n_window = r_window << i_item.need;
                        n_bits   = r_bits - i_item.need;
                        value    = head;
                    end
                    if (i_item.op == OP_SKIP) begin
                        value = '0;
                    end
                end
                OP_SKIP_LONG: begin
                    // The offset is biased by two words to keep it positive.
                    n_ptr     = r_ptr + WORD_ADDR_BITS'(offset >> SHIFT_W)
                                - WORD_ADDR_BITS'(2);
                    n_shift   = offset[SHIFT_W-1:0];
                    n_pending = 1'b1;
                end
                OP_START: begin
                    n_ptr     = WORD_ADDR_BITS'(i_item.count >> 2);
                    n_shift   = {i_item.count[1:0], 3'b000};
                    n_pending = 1'b1;
                end
                OP_LOAD: begin
                    n_window  = swapped << r_shift;
                    n_bits    = WINDOW_FULL - BITS_W'(r_shift);
                    n_ptr     = r_ptr + WORD_ADDR_BITS'(1);
                    n_pending = 1'b0;
                    n_shift   = '0;
                    taken     = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= '0;
            r_bits      <= '0;
            r_ptr       <= '0;
            r_pending   <= 1'b0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_window  <= n_window;
                r_bits    <= n_bits;
                r_ptr     <= n_ptr;
                r_pending <= n_pending;
                r_shift   <= n_shift;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_value <= value;
            r_taken <= taken;
            r_bad   <= bad;
        end
    end

    // The state registers already hold the post-item pointer and pending flag.
    assign ptr_ext        = ExtW'(r_ptr);
    assign o_out_valid    = r_out_valid;
    assign o_value        = r_value;
    assign o_word_address = ptr_ext[OUT_ADDR_W-1:0];
    assign o_word_taken   = r_taken;
    assign o_load_needed  = r_pending;
    assign o_bad_order    = r_bad;

endmodule
`default_nettype wire

>>> rtl/msb_first_bit_reader.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msb_first_bit_reader
// MSB-first bitstream reader over 32-bit memory words with load ordering.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                    Payload
//  -------  ---------  ---------------------------  ---------------------------
//  in       to block   i_in_valid / o_in_stall      i_func, i_count, i_word
//  out      from block o_out_valid / i_out_stall    o_value, o_word_address,
//                                                   o_word_taken,
//                                                   o_load_needed, o_bad_order
//
//  One transfer in gives exactly one transfer out. The sustained rate is one
//  item per cycle while the output is not stalled; each result passes through
//  the queue and then the result register before it appears.
//  The rate is set by the execution stage, which updates the bit window and
//  word pointer once per item with combinational shifts, adds and a compare.
//  Reset is synchronous and active low; it empties the queue and clears the
//  window, pointer and pending load. No clearing pass is needed after reset.
//  A stall on the output holds the result register; the two-entry queue keeps
//  taking transfers until it fills, then the input stalls.
//
module msb_first_bit_reader #(
    parameter int WORD_ADDR_BITS = 24
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [mfbr_pkg::FUNC_W-1:0]       i_func,
    input  wire logic [mfbr_pkg::COUNT_W-1:0]      i_count,
    input  wire logic [mfbr_pkg::WORD_W-1:0]       i_word,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [mfbr_pkg::WORD_W-1:0]           o_value,
    output logic [mfbr_pkg::OUT_ADDR_W-1:0]       o_word_address,
    output logic                                  o_word_taken,
    output logic                                  o_load_needed,
    output logic                                  o_bad_order
);
    import mfbr_pkg::*;

    logic       push;
    logic       pop;
    t_item      front_item;
    t_item      head_item;
    logic       queue_empty;
    logic       queue_full;
    logic [1:0] queue_level;

    // The front end decodes the function code so that the execution stage
    // sees an operation class and the bits it needs beside the raw count and word.
    mfbr_front u_front (
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_count      (i_count),
        .i_word       (i_word),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_item       (front_item)
    );

    // The queue lets the front end keep taking transfers while the result
    // register is stalled, and the back end drain while the input is idle.
    mfbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_empty (queue_empty),
        .o_full  (queue_full),
        .o_level (queue_level)
    );

    // The back end owns all reader state. Ordering violations are detected
    // here since they depend on whether a load word is pending.
    mfbr_back #(
        .WORD_ADDR_BITS (WORD_ADDR_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (!queue_empty),
        .i_item         (head_item),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_value        (o_value),
        .o_word_address (o_word_address),
        .o_word_taken   (o_word_taken),
        .o_load_needed  (o_load_needed),
        .o_bad_order    (o_bad_order)
    );

    // An ignored item neither consumes the word nor returns any bits.
    a_bad_is_inert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_order |-> !o_word_taken && o_value == '0)
        else $error("ignored item consumed a word or returned data");

    // An item that leaves a load pending never consumes the supplied word.
    a_pending_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_load_needed |-> !o_word_taken)
        else $error("word taken while a load is still pending");

    // The queue never holds more than its two entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        queue_level <= 2'd2)
        else $error("item queue overflow");

    // A transfer popped from the queue always lands in the result register.
    a_pop_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> o_out_valid)
        else $error("popped item did not produce a result");

endmodule
`default_nettype wire
